// ----- design/psrc_pkg.sv -----
// Shared constants, types and helpers for the permutation swap round counter.
`default_nettype none

package psrc_pkg;

   localparam int MAX_VALUES = 4096;
   localparam int ADDR_W     = $clog2(MAX_VALUES);
   localparam int VAL_W      = 13;
   localparam int CMD_W      = 2;
   localparam int PADDR_W    = 2;
   localparam int PDATA_W    = 32;

   localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_COUNT = 2'd1;
   localparam logic [CMD_W-1:0] CMD_SWAP  = 2'd2;

   localparam logic [PADDR_W-1:0] ADDR_COUNT_IN_USE = '0;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOAD,
      ST_COUNT,
      ST_VREAD,
      ST_PREAD0,
      ST_PREAD1,
      ST_PREAD2,
      ST_CAP0,
      ST_WRITE0,
      ST_WRITE1,
      ST_DONE
   } state_type;

   // values at the two swap positions and the positions around them
   typedef struct packed {
      logic [VAL_W-1:0]  a;
      logic [VAL_W-1:0]  b;
      logic [ADDR_W-1:0] pos_a2;
      logic [ADDR_W-1:0] pos_a1;
      logic [ADDR_W-1:0] pos_a0;
      logic [ADDR_W-1:0] pos_b2;
      logic [ADDR_W-1:0] pos_b1;
      logic [ADDR_W-1:0] pos_b0;
   } swap_view_type;

   typedef struct packed {
      logic [VAL_W-1:0]  delta;
      logic [ADDR_W-1:0] pa;
      logic [ADDR_W-1:0] pb;
      logic              a_in;
      logic              b_in;
   } swap_res_type;

   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] waddr;
      logic [VAL_W-1:0]  wdata;
      logic [ADDR_W-1:0] raddr_a;
      logic [ADDR_W-1:0] raddr_b;
   } val_mem_type;

   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] waddr;
      logic [ADDR_W-1:0] wdata;
      logic [ADDR_W-1:0] raddr_a;
      logic [ADDR_W-1:0] raddr_b;
   } pos_mem_type;

   function automatic logic in_range(input logic [VAL_W:0] x, input logic [VAL_W-1:0] n);
      return (x != '0) && (x <= {1'b0, n});
   endfunction

endpackage

`default_nettype wire

// ----- design/psrc_ram.sv -----
// Generic RAM: one write port, two registered read ports.
`default_nettype none

module psrc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                          clock,
   input  wire logic                          we,
   input  wire logic [$clog2(DEPTH)-1:0]      waddr,
   input  wire logic [WIDTH-1:0]              wdata,
   input  wire logic [$clog2(DEPTH)-1:0]      raddr_a,
   input  wire logic [$clog2(DEPTH)-1:0]      raddr_b,
   output logic      [WIDTH-1:0]              rdata_a,
   output logic      [WIDTH-1:0]              rdata_b
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_a_ff;
   logic [WIDTH-1:0] rdata_b_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_a_ff <= mem[raddr_a];
      rdata_b_ff <= mem[raddr_b];
   end

   assign rdata_a = rdata_a_ff;
   assign rdata_b = rdata_b_ff;

endmodule

`default_nettype wire

// ----- design/psrc_csr.sv -----
// APB register file: count_in_use and the clamped active value count.
`default_nettype none

module psrc_csr (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            psel,
   input  wire logic                            penable,
   input  wire logic                            pwrite,
   input  wire logic [psrc_pkg::PADDR_W-1:0]    paddr,
   input  wire logic [psrc_pkg::PDATA_W-1:0]    pwdata,
   output logic      [psrc_pkg::PDATA_W-1:0]    prdata,
   output logic                                 pready,
   output logic      [psrc_pkg::VAL_W-1:0]      n_o
);

   logic [psrc_pkg::VAL_W-1:0] count_ff;
   logic [psrc_pkg::VAL_W-1:0] count_in;
   logic                       wr_hit;

   assign pready = 1'b1;
   assign wr_hit = psel && penable && pwrite && (paddr == psrc_pkg::ADDR_COUNT_IN_USE);

   always_comb begin
      count_in = count_ff;
      if (wr_hit) begin
         count_in = pwdata[psrc_pkg::VAL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= psrc_pkg::VAL_W'(1);
      end else begin
         count_ff <= count_in;
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr == psrc_pkg::ADDR_COUNT_IN_USE) begin
         prdata = psrc_pkg::PDATA_W'(count_ff);
      end
   end

   // zero acts as one, anything above the table depth saturates
   always_comb begin
      if (count_ff == '0) begin
         n_o = psrc_pkg::VAL_W'(1);
      end else if (count_ff > psrc_pkg::VAL_W'(psrc_pkg::MAX_VALUES)) begin
         n_o = psrc_pkg::VAL_W'(psrc_pkg::MAX_VALUES);
      end else begin
         n_o = count_ff;
      end
   end

endmodule

`default_nettype wire

// ----- design/psrc_delta.sv -----
// Round-count change of a swap from the old positions around both values.
`default_nettype none

module psrc_delta (
   input  wire psrc_pkg::swap_view_type     view_i,
   input  wire logic [psrc_pkg::VAL_W-1:0]  n_i,
   output psrc_pkg::swap_res_type           res_o
);

   localparam int VW = psrc_pkg::VAL_W;
   localparam int AW = psrc_pkg::ADDR_W;

   logic [VW:0]   cand   [4];
   logic [AW-1:0] hi_idx [4];
   logic [AW-1:0] lo_idx [4];
   logic [AW-1:0] hi_old [4];
   logic [AW-1:0] lo_old [4];
   logic [AW-1:0] hi_new [4];
   logic [AW-1:0] lo_new [4];
   logic          ok     [4];
   logic          use_c  [4];
   logic          a_in;
   logic          b_in;
   logic [AW-1:0] a_m1;
   logic [AW-1:0] b_m1;
   logic [AW-1:0] pa;
   logic [AW-1:0] pb;
   logic [2:0]    add_cnt;
   logic [2:0]    sub_cnt;

   always_comb begin
      a_in = psrc_pkg::in_range({1'b0, view_i.a}, n_i);
      b_in = psrc_pkg::in_range({1'b0, view_i.b}, n_i);
      a_m1 = AW'(view_i.a - VW'(1));
      b_m1 = AW'(view_i.b - VW'(1));
      pa   = a_in ? view_i.pos_a1 : '0;
      pb   = b_in ? view_i.pos_b1 : '0;

      cand[0] = {1'b0, view_i.a};
      cand[1] = {1'b0, view_i.a} + (VW+1)'(1);
      cand[2] = {1'b0, view_i.b};
      cand[3] = {1'b0, view_i.b} + (VW+1)'(1);

      hi_old[0] = view_i.pos_a1;  lo_old[0] = view_i.pos_a2;
      hi_old[1] = view_i.pos_a0;  lo_old[1] = view_i.pos_a1;
      hi_old[2] = view_i.pos_b1;  lo_old[2] = view_i.pos_b2;
      hi_old[3] = view_i.pos_b0;  lo_old[3] = view_i.pos_b1;

      add_cnt = '0;
      sub_cnt = '0;
      for (int k = 0; k < 4; k++) begin
         hi_idx[k] = AW'(cand[k] - (VW+1)'(1));
         lo_idx[k] = AW'(cand[k] - (VW+1)'(2));
         ok[k]     = psrc_pkg::in_range(cand[k], n_i) && (cand[k] >= (VW+1)'(2));
      end
      for (int k = 0; k < 4; k++) begin
         use_c[k] = ok[k];
         for (int m = 0; m < 4; m++) begin
            if ((m < k) && ok[m] && (cand[m] == cand[k])) begin
               use_c[k] = 1'b0;
            end
         end
         // positions after the swap: only the entries of a and b move
         if (a_in && (hi_idx[k] == a_m1)) begin
            hi_new[k] = pb;
         end else if (b_in && (hi_idx[k] == b_m1)) begin
            hi_new[k] = pa;
         end else begin
            hi_new[k] = hi_old[k];
         end
         if (a_in && (lo_idx[k] == a_m1)) begin
            lo_new[k] = pb;
         end else if (b_in && (lo_idx[k] == b_m1)) begin
            lo_new[k] = pa;
         end else begin
            lo_new[k] = lo_old[k];
         end
         if (use_c[k] && (hi_old[k] < lo_old[k])) begin
            sub_cnt = sub_cnt + 3'd1;
         end
         if (use_c[k] && (hi_new[k] < lo_new[k])) begin
            add_cnt = add_cnt + 3'd1;
         end
      end

      res_o.delta = VW'(add_cnt) - VW'(sub_cnt);
      res_o.pa    = pa;
      res_o.pb    = pb;
      res_o.a_in  = a_in;
      res_o.b_in  = b_in;
   end

endmodule

`default_nettype wire

// ----- design/psrc_ctrl.sv -----
// Command sequencer: memory access schedule, count walk, swap update, result register.
`default_nettype none

module psrc_ctrl (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [psrc_pkg::VAL_W-1:0]    n_i,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [psrc_pkg::CMD_W-1:0]    req_command,
   input  wire logic [psrc_pkg::VAL_W-1:0]    req_first_position,
   input  wire logic [psrc_pkg::VAL_W-1:0]    req_second_position,
   input  wire logic [psrc_pkg::VAL_W-1:0]    req_load_value,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic      [psrc_pkg::VAL_W-1:0]    rsp_rounds,
   output psrc_pkg::val_mem_type              val_mem_o,
   input  wire logic [psrc_pkg::VAL_W-1:0]    val_rdata_a_i,
   input  wire logic [psrc_pkg::VAL_W-1:0]    val_rdata_b_i,
   output psrc_pkg::pos_mem_type              pos_mem_o,
   input  wire logic [psrc_pkg::ADDR_W-1:0]   pos_rdata_a_i,
   input  wire logic [psrc_pkg::ADDR_W-1:0]   pos_rdata_b_i
);

   localparam int VW = psrc_pkg::VAL_W;
   localparam int AW = psrc_pkg::ADDR_W;

   psrc_pkg::state_type     state_ff, state_in;
   logic [AW-1:0]           p1_ff, p1_in;
   logic [AW-1:0]           p2_ff, p2_in;
   logic [VW-1:0]           lv_ff, lv_in;
   psrc_pkg::swap_view_type view_ff, view_in;
   logic [VW-1:0]           cnt_ff, cnt_in;
   logic                    rdv_ff, rdv_in;
   logic                    first_ff, first_in;
   logic [AW-1:0]           prev_ff, prev_in;
   logic [VW-1:0]           total_ff, total_in;
   logic [VW-1:0]           delta_ff, delta_in;
   logic [VW-1:0]           result_ff, result_in;
   logic [VW-1:0]           round_total_ff, round_total_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [VW-1:0]           rsp_rounds_ff, rsp_rounds_in;

   psrc_pkg::swap_res_type  swap_res;
   logic                    accept;
   logic                    issue;
   logic                    count_done;
   logic                    out_free;
   logic                    load_ok;
   logic                    swap_ok;
   logic [AW-1:0]           lv_m1;
   logic [AW-1:0]           a_m1;
   logic [AW-1:0]           b_m1;

   psrc_delta u_delta (
      .view_i (view_ff),
      .n_i    (n_i),
      .res_o  (swap_res)
   );

   assign accept     = req_valid && req_ready;
   assign issue      = cnt_ff < n_i;
   assign count_done = !issue && !rdv_ff;
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign load_ok    = psrc_pkg::in_range({1'b0, req_first_position}, n_i)
                    && psrc_pkg::in_range({1'b0, req_load_value}, n_i);
   assign swap_ok    = psrc_pkg::in_range({1'b0, req_first_position}, n_i)
                    && psrc_pkg::in_range({1'b0, req_second_position}, n_i);
   assign lv_m1      = AW'(lv_ff - VW'(1));
   assign a_m1       = AW'(view_ff.a - VW'(1));
   assign b_m1       = AW'(view_ff.b - VW'(1));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         psrc_pkg::ST_IDLE: begin
            if (accept) begin
               case (req_command)
                  psrc_pkg::CMD_LOAD: begin
                     if (load_ok) state_in = psrc_pkg::ST_LOAD;
                  end
                  psrc_pkg::CMD_COUNT: begin
                     state_in = psrc_pkg::ST_COUNT;
                  end
                  psrc_pkg::CMD_SWAP: begin
                     if (swap_ok) state_in = psrc_pkg::ST_VREAD;
                  end
                  default: begin
                     state_in = psrc_pkg::ST_IDLE;
                  end
               endcase
            end
         end
         psrc_pkg::ST_LOAD:   state_in = psrc_pkg::ST_IDLE;
         psrc_pkg::ST_COUNT: begin
            if (count_done) state_in = psrc_pkg::ST_DONE;
         end
         psrc_pkg::ST_VREAD:  state_in = psrc_pkg::ST_PREAD0;
         psrc_pkg::ST_PREAD0: state_in = psrc_pkg::ST_PREAD1;
         psrc_pkg::ST_PREAD1: state_in = psrc_pkg::ST_PREAD2;
         psrc_pkg::ST_PREAD2: state_in = psrc_pkg::ST_CAP0;
         psrc_pkg::ST_CAP0:   state_in = psrc_pkg::ST_WRITE0;
         psrc_pkg::ST_WRITE0: state_in = psrc_pkg::ST_WRITE1;
         psrc_pkg::ST_WRITE1: state_in = psrc_pkg::ST_DONE;
         psrc_pkg::ST_DONE: begin
            if (out_free) state_in = psrc_pkg::ST_IDLE;
         end
         default: state_in = psrc_pkg::ST_IDLE;
      endcase
   end

   // memory ports and handshake
   always_comb begin
      req_ready         = 1'b0;
      val_mem_o.we      = 1'b0;
      val_mem_o.waddr   = p1_ff;
      val_mem_o.wdata   = view_ff.b;
      val_mem_o.raddr_a = p1_ff;
      val_mem_o.raddr_b = p2_ff;
      pos_mem_o.we      = 1'b0;
      pos_mem_o.waddr   = lv_m1;
      pos_mem_o.wdata   = p1_ff;
      pos_mem_o.raddr_a = cnt_ff[AW-1:0];
      pos_mem_o.raddr_b = '0;
      case (state_ff)
         psrc_pkg::ST_IDLE: begin
            req_ready = 1'b1;
         end
         psrc_pkg::ST_LOAD: begin
            val_mem_o.we    = 1'b1;
            val_mem_o.wdata = lv_ff;
            pos_mem_o.we    = 1'b1;
         end
         psrc_pkg::ST_PREAD0: begin
            pos_mem_o.raddr_a = AW'(val_rdata_a_i - VW'(1));
            pos_mem_o.raddr_b = AW'(val_rdata_b_i - VW'(1));
         end
         psrc_pkg::ST_PREAD1: begin
            pos_mem_o.raddr_a = view_ff.a[AW-1:0];
            pos_mem_o.raddr_b = view_ff.b[AW-1:0];
         end
         psrc_pkg::ST_PREAD2: begin
            pos_mem_o.raddr_a = AW'(view_ff.a - VW'(2));
            pos_mem_o.raddr_b = AW'(view_ff.b - VW'(2));
         end
         psrc_pkg::ST_WRITE0: begin
            val_mem_o.we    = 1'b1;
            pos_mem_o.we    = swap_res.a_in;
            pos_mem_o.waddr = a_m1;
            pos_mem_o.wdata = swap_res.pb;
         end
         psrc_pkg::ST_WRITE1: begin
            val_mem_o.we    = 1'b1;
            val_mem_o.waddr = p2_ff;
            val_mem_o.wdata = view_ff.a;
            pos_mem_o.we    = swap_res.b_in;
            pos_mem_o.waddr = b_m1;
            pos_mem_o.wdata = swap_res.pa;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // datapath
   always_comb begin
      p1_in          = p1_ff;
      p2_in          = p2_ff;
      lv_in          = lv_ff;
      view_in        = view_ff;
      cnt_in         = cnt_ff;
      rdv_in         = 1'b0;
      first_in       = first_ff;
      prev_in        = prev_ff;
      total_in       = total_ff;
      delta_in       = delta_ff;
      result_in      = result_ff;
      round_total_in = round_total_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_rounds_in  = rsp_rounds_ff;
      case (state_ff)
         psrc_pkg::ST_IDLE: begin
            if (accept) begin
               p1_in    = AW'(req_first_position - VW'(1));
               p2_in    = AW'(req_second_position - VW'(1));
               lv_in    = req_load_value;
               cnt_in   = '0;
               total_in = VW'(1);
            end
         end
         psrc_pkg::ST_COUNT: begin
            if (issue) begin
               cnt_in   = cnt_ff + VW'(1);
               rdv_in   = 1'b1;
               first_in = (cnt_ff == '0);
            end
            if (rdv_ff) begin
               prev_in = pos_rdata_a_i;
               if (!first_ff && (pos_rdata_a_i < prev_ff)) begin
                  total_in = total_ff + VW'(1);
               end
            end
            if (count_done) begin
               result_in      = total_ff;
               round_total_in = total_ff;
            end
         end
         psrc_pkg::ST_PREAD0: begin
            view_in.a = val_rdata_a_i;
            view_in.b = val_rdata_b_i;
         end
         psrc_pkg::ST_PREAD1: begin
            view_in.pos_a1 = pos_rdata_a_i;
            view_in.pos_b1 = pos_rdata_b_i;
         end
         psrc_pkg::ST_PREAD2: begin
            view_in.pos_a0 = pos_rdata_a_i;
            view_in.pos_b0 = pos_rdata_b_i;
         end
         psrc_pkg::ST_CAP0: begin
            view_in.pos_a2 = pos_rdata_a_i;
            view_in.pos_b2 = pos_rdata_b_i;
         end
         psrc_pkg::ST_WRITE0: begin
            delta_in = swap_res.delta;
         end
         psrc_pkg::ST_WRITE1: begin
            result_in      = round_total_ff + delta_ff;
            round_total_in = round_total_ff + delta_ff;
         end
         psrc_pkg::ST_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_rounds_in = result_ff;
            end
         end
         default: begin
            rdv_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= psrc_pkg::ST_IDLE;
         rdv_ff         <= 1'b0;
         round_total_ff <= VW'(1);
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         rdv_ff         <= rdv_in;
         round_total_ff <= round_total_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      p1_ff         <= p1_in;
      p2_ff         <= p2_in;
      lv_ff         <= lv_in;
      view_ff       <= view_in;
      cnt_ff        <= cnt_in;
      first_ff      <= first_in;
      prev_ff       <= prev_in;
      total_ff      <= total_in;
      delta_ff      <= delta_in;
      result_ff     <= result_in;
      rsp_rounds_ff <= rsp_rounds_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_rounds = rsp_rounds_ff;

endmodule

`default_nettype wire

// ----- design/permutation_swap_round_counter.sv -----
// Top level: permutation tables in two RAMs, round count under load/count/swap commands.
// Load: accept, then write; no result beat.
// Count: one position read per cycle, then the result beat.
// Swap: table reads (VREAD to CAP0), then writes (WRITE0, WRITE1), then the result beat.
// One command at a time; the next is taken as soon as the sequencer is idle again.
// Synchronous active-high reset: round total and count_in_use to one; tables are not cleared.
`default_nettype none

module permutation_swap_round_counter (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // command channel
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [psrc_pkg::CMD_W-1:0]    req_command,
   input  wire logic [psrc_pkg::VAL_W-1:0]    req_first_position,
   input  wire logic [psrc_pkg::VAL_W-1:0]    req_second_position,
   input  wire logic [psrc_pkg::VAL_W-1:0]    req_load_value,
   // result channel
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic      [psrc_pkg::VAL_W-1:0]    rsp_rounds,
   // APB register port
   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic [psrc_pkg::PADDR_W-1:0]  paddr,
   input  wire logic [psrc_pkg::PDATA_W-1:0]  pwdata,
   output logic      [psrc_pkg::PDATA_W-1:0]  prdata,
   output logic                               pready
);

   // active value count n, already clamped to 1..MAX_VALUES
   logic [psrc_pkg::VAL_W-1:0]  n_active;

   // sequencer <-> table RAMs
   psrc_pkg::val_mem_type       val_mem;
   psrc_pkg::pos_mem_type       pos_mem;
   logic [psrc_pkg::VAL_W-1:0]  val_rdata_a;
   logic [psrc_pkg::VAL_W-1:0]  val_rdata_b;
   logic [psrc_pkg::ADDR_W-1:0] pos_rdata_a;
   logic [psrc_pkg::ADDR_W-1:0] pos_rdata_b;

   psrc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .n_o     (n_active)
   );

   // position -> value table; both read ports serve the two swap positions
   psrc_ram #(
      .WIDTH (psrc_pkg::VAL_W),
      .DEPTH (psrc_pkg::MAX_VALUES)
   ) u_val_ram (
      .clock   (clock),
      .we      (val_mem.we),
      .waddr   (val_mem.waddr),
      .wdata   (val_mem.wdata),
      .raddr_a (val_mem.raddr_a),
      .raddr_b (val_mem.raddr_b),
      .rdata_a (val_rdata_a),
      .rdata_b (val_rdata_b)
   );

   // value -> 0-based position table; port A walks it during a count,
   // A and B fetch the neighbors of the two swapped values
   psrc_ram #(
      .WIDTH (psrc_pkg::ADDR_W),
      .DEPTH (psrc_pkg::MAX_VALUES)
   ) u_pos_ram (
      .clock   (clock),
      .we      (pos_mem.we),
      .waddr   (pos_mem.waddr),
      .wdata   (pos_mem.wdata),
      .raddr_a (pos_mem.raddr_a),
      .raddr_b (pos_mem.raddr_b),
      .rdata_a (pos_rdata_a),
      .rdata_b (pos_rdata_b)
   );

   // The sequencer never reads and writes the same table in one cycle:
   // all reads of a swap finish before its write-back, so no forwarding
   // path is needed.  The result beat sits in an output register, so a
   // new command is taken while an earlier result still waits.
   psrc_ctrl u_ctrl (
      .clock               (clock),
      .reset               (reset),
      .n_i                 (n_active),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_command         (req_command),
      .req_first_position  (req_first_position),
      .req_second_position (req_second_position),
      .req_load_value      (req_load_value),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_rounds          (rsp_rounds),
      .val_mem_o           (val_mem),
      .val_rdata_a_i       (val_rdata_a),
      .val_rdata_b_i       (val_rdata_b),
      .pos_mem_o           (pos_mem),
      .pos_rdata_a_i       (pos_rdata_a),
      .pos_rdata_b_i       (pos_rdata_b)
   );

   // a count beat always starts a walk, so the port closes right after it
   a_count_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_command == psrc_pkg::CMD_COUNT)) |=> !req_ready)
      else $error("count command did not start the walk");

   // position table writes address a value inside 1..n; the stored
   // position may come from a larger n and is not bounded
   a_pos_write: assert property (@(posedge clock) disable iff (reset)
      pos_mem.we |-> ({1'b0, pos_mem.waddr} < n_active))
      else $error("position table write outside the active range");

   // value table writes stay inside 0..n-1
   a_val_write: assert property (@(posedge clock) disable iff (reset)
      val_mem.we |-> ({1'b0, val_mem.waddr} < n_active))
      else $error("value table write outside the active range");

endmodule

`default_nettype wire

// ----- bench/psrc_round_checker.sv -----
// Checker for the permutation swap round counter: watches both channels and the register port.
module psrc_round_checker
   import psrc_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   input  wire logic               req_ready,
   input  wire logic [CMD_W-1:0]   req_command,
   input  wire logic [VAL_W-1:0]   req_first_position,
   input  wire logic [VAL_W-1:0]   req_second_position,
   input  wire logic [VAL_W-1:0]   req_load_value,
   input  wire logic               rsp_valid,
   input  wire logic               rsp_ready,
   input  wire logic [VAL_W-1:0]   rsp_rounds,
   input  wire logic               psel,
   input  wire logic               penable,
   input  wire logic               pwrite,
   input  wire logic [PADDR_W-1:0] paddr,
   input  wire logic [PDATA_W-1:0] pwdata,
   input  wire logic               pready,
   output int unsigned             mismatches,
   output int unsigned             awaited
);

   // shadow tables; place_of entries hold 0-based positions
   logic [VAL_W-1:0]  value_at [MAX_VALUES];
   logic [ADDR_W-1:0] place_of [MAX_VALUES];
   logic [VAL_W-1:0]  rounds_now;
   logic [VAL_W-1:0]  values_reg;
   logic [VAL_W-1:0]  rounds_due [$];
   logic [VAL_W-1:0]  due;
   int unsigned       errors = 0;

   assign mismatches = errors;

   function automatic int unsigned live_n();
      if (values_reg == '0) return 1;
      if (values_reg > MAX_VALUES) return MAX_VALUES;
      return values_reg;
   endfunction

   function automatic bit fits(input int unsigned x, input int unsigned n);
      return x >= 1 && x <= n;
   endfunction

   // 1 when value v sits before value v-1
   function automatic int unsigned descent(input int unsigned v, input int unsigned n);
      if (v < 2 || v > n) return 0;
      return (place_of[v-1] < place_of[v-2]) ? 1 : 0;
   endfunction

   task automatic apply_command(input logic [CMD_W-1:0] cmd, input logic [VAL_W-1:0] p1,
                                input logic [VAL_W-1:0] p2, input logic [VAL_W-1:0] lv);
      int unsigned n, a, b, pa, pb, cnt, total, k, m;
      int unsigned cand [4];
      int unsigned hit [4];
      bit          dup;
      n = live_n();
      case (cmd)
         CMD_LOAD: begin
            if (fits(p1, n) && fits(lv, n)) begin
               value_at[p1-1] = lv;
               place_of[lv-1] = p1 - 1;
            end
         end
         CMD_COUNT: begin
            total = 1;
            for (k = 2; k <= n; k++) total += descent(k, n);
            rounds_now = total;
            rounds_due.push_back(rounds_now);
         end
         CMD_SWAP: begin
            if (fits(p1, n) && fits(p2, n)) begin
               a = value_at[p1-1];
               b = value_at[p2-1];
               cand[0] = a;
               cand[1] = a + 1;
               cand[2] = b;
               cand[3] = b + 1;
               cnt = 0;
               for (k = 0; k < 4; k++) begin
                  if (fits(cand[k], n)) begin
                     dup = 1'b0;
                     for (m = 0; m < cnt; m++) if (hit[m] == cand[k]) dup = 1'b1;
                     if (!dup) begin
                        hit[cnt] = cand[k];
                        cnt++;
                     end
                  end
               end
               for (k = 0; k < cnt; k++) rounds_now = rounds_now - descent(hit[k], n);
               value_at[p1-1] = b;
               value_at[p2-1] = a;
               pa = fits(a, n) ? place_of[a-1] : 0;
               pb = fits(b, n) ? place_of[b-1] : 0;
               if (fits(a, n)) place_of[a-1] = pb;
               if (fits(b, n)) place_of[b-1] = pa;
               for (k = 0; k < cnt; k++) rounds_now = rounds_now + descent(hit[k], n);
               rounds_due.push_back(rounds_now);
            end
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rounds_now = 1;
         values_reg = 1;
         rounds_due.delete();
      end else begin
         if (psel && penable && pwrite && pready && paddr == ADDR_COUNT_IN_USE)
            values_reg = pwdata[VAL_W-1:0];
         if (req_valid && req_ready)
            apply_command(req_command, req_first_position, req_second_position, req_load_value);
         if (rsp_valid && rsp_ready) begin
            if (rounds_due.size() == 0) begin
               $display("%0t: unexpected result beat, expected none, got rounds %0d",
                        $time, rsp_rounds);
               errors++;
            end else begin
               due = rounds_due.pop_front();
               if (rsp_rounds !== due) begin
                  $display("%0t: rounds mismatch, expected %0d, got %0d",
                           $time, due, rsp_rounds);
                  errors++;
               end
            end
         end
      end
      awaited <= rounds_due.size();
   end

endmodule

// ----- bench/tb_permutation_swap_round_counter.sv -----
// Testbench top: drives commands and register writes, and gives the verdict.
module tb_permutation_swap_round_counter;
   import psrc_pkg::*;

   localparam int unsigned      CYCLE_LIMIT   = 1_000_000;
   // longest no-result work is a load (accept, then write); keep a margin
   localparam int unsigned      SETTLE_CYCLES = 16;
   // loaded prefix used while n sits at the table size
   localparam int unsigned      WIDE_SPAN     = 100;
   localparam logic [CMD_W-1:0] CMD_UNUSED    = 2'd3;
   localparam logic [VAL_W-1:0] FIELD_MAX     = '1;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [CMD_W-1:0]   req_command = '0;
   logic [VAL_W-1:0]   req_first_position = '0;
   logic [VAL_W-1:0]   req_second_position = '0;
   logic [VAL_W-1:0]   req_load_value = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [VAL_W-1:0]   rsp_rounds;
   logic               psel = 1'b0;
   logic               penable = 1'b0;
   logic               pwrite = 1'b0;
   logic [PADDR_W-1:0] paddr = '0;
   logic [PDATA_W-1:0] pwdata = '0;
   logic [PDATA_W-1:0] prdata;
   logic               pready;

   int unsigned mismatches;
   int unsigned awaited;
   int unsigned cycles = 0;
   // highest n for which every position and value 1..n has been loaded;
   // counts are only sent while n stays at or below it, swaps also above it in wide_phase
   int unsigned loaded_upto = 0;
   // last full load, position-1 -> value
   int unsigned order [MAX_VALUES];
   // when set, neither side idles
   logic        quiet = 1'b0;

   permutation_swap_round_counter dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_command         (req_command),
      .req_first_position  (req_first_position),
      .req_second_position (req_second_position),
      .req_load_value      (req_load_value),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_rounds          (rsp_rounds),
      .psel                (psel),
      .penable             (penable),
      .pwrite              (pwrite),
      .paddr               (paddr),
      .pwdata              (pwdata),
      .prdata              (prdata),
      .pready              (pready)
   );

   psrc_round_checker u_checker (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_command         (req_command),
      .req_first_position  (req_first_position),
      .req_second_position (req_second_position),
      .req_load_value      (req_load_value),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_rounds          (rsp_rounds),
      .psel                (psel),
      .penable             (penable),
      .pwrite              (pwrite),
      .paddr               (paddr),
      .pwdata              (pwdata),
      .pready              (pready),
      .mismatches          (mismatches),
      .awaited             (awaited)
   );

   always #5 clock = ~clock;

   // run limit, far above the slowest legal run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // result side: back-pressure about 15% of cycles unless quiet
   always @(posedge clock) begin
      rsp_ready <= !reset && (quiet || $urandom_range(99) >= 15);
   end

   function automatic logic [VAL_W-1:0] any_field();
      return $urandom_range((1 << VAL_W) - 1, 0);
   endfunction

   function automatic int unsigned effective_n(input logic [VAL_W-1:0] reg_value);
      if (reg_value == '0) return 1;
      if (reg_value > MAX_VALUES) return MAX_VALUES;
      return reg_value;
   endfunction

   // One command beat. Valid is lowered only when a gap is taken, so valid is
   // never dropped and raised in the same step. Ready is sampled at the
   // falling edge, where it already holds its value for the next rising edge.
   task automatic send(input logic [CMD_W-1:0] cmd, input logic [VAL_W-1:0] p1,
                       input logic [VAL_W-1:0] p2, input logic [VAL_W-1:0] lv);
      bit taken;
      if (!quiet && $urandom_range(99) < 15) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < 40) @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_command         <= cmd;
      req_first_position  <= p1;
      req_second_position <= p2;
      req_load_value      <= lv;
      do begin
         @(negedge clock);
         taken = req_ready;
         @(posedge clock);
      end while (!taken);
   endtask

   // Hold off the sender until every predicted beat has come back, then let
   // a trailing load finish before anything else touches the block.
   task automatic drain();
      req_valid <= 1'b0;
      do @(negedge clock); while (awaited != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // APB write: setup, then access until pready
   task automatic write_count_in_use(input logic [VAL_W-1:0] reg_value);
      bit done;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= ADDR_COUNT_IN_USE;
      pwdata  <= PDATA_W'(reg_value);
      @(posedge clock);
      penable <= 1'b1;
      do begin
         @(negedge clock);
         done = pready;
         @(posedge clock);
      end while (!done);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // shuffled full permutation of 1..n, one load beat per position
   task automatic load_permutation(input int unsigned n);
      int unsigned i, j, t;
      for (i = 0; i < n; i++) order[i] = i + 1;
      for (i = n - 1; i > 0; i--) begin
         j = $urandom_range(i, 0);
         t = order[i];
         order[i] = order[j];
         order[j] = t;
      end
      for (i = 0; i < n; i++) send(CMD_LOAD, i + 1, any_field(), order[i]);
      if (n > loaded_upto) loaded_upto = n;
   endtask

   // Mostly in-range swaps; counts are kept rare at large n since they walk
   // the whole table. Loads in range break the permutation on purpose; the
   // remainder is noise with every field random.
   task automatic random_item(input int unsigned n);
      int unsigned pick;
      logic [VAL_W-1:0] x, y;
      pick = $urandom_range(99);
      x = $urandom_range(n, 1);
      y = ($urandom_range(9) == 0) ? x : $urandom_range(n, 1);
      if (pick < 60)
         send(CMD_SWAP, x, y, any_field());
      else if (pick < ((n > 256) ? 62 : 70))
         send(CMD_COUNT, any_field(), any_field(), any_field());
      else if (pick < 85)
         send(CMD_LOAD, x, any_field(), y);
      else
         send($urandom_range((1 << CMD_W) - 1, 0), any_field(), any_field(), any_field());
   endtask

   task automatic run_phase(input logic [VAL_W-1:0] reg_value, input bit do_count,
                            input int unsigned items);
      int unsigned n;
      n = effective_n(reg_value);
      drain();
      write_count_in_use(reg_value);
      if (n > loaded_upto) load_permutation(n);
      if (do_count) send(CMD_COUNT, any_field(), any_field(), any_field());
      repeat (items) random_item(n);
   endtask

   // n at the table size: only positions 1..WIDE_SPAN hold loaded values,
   // so swaps and loads stay there and no count walks the table. Value
   // WIDE_SPAN+1 is placed once so every neighbor a swap looks at is written.
   // Must follow a phase that loaded WIDE_SPAN values.
   task automatic wide_phase(input logic [VAL_W-1:0] reg_value, input int unsigned items);
      int unsigned k, pick;
      logic [VAL_W-1:0] x, y;
      drain();
      write_count_in_use(reg_value);
      send(CMD_LOAD, VAL_W'(WIDE_SPAN + 1), any_field(), VAL_W'(WIDE_SPAN + 1));
      for (k = 0; k < items; k++) begin
         pick = $urandom_range(99);
         x = VAL_W'($urandom_range(WIDE_SPAN, 1));
         y = ($urandom_range(9) == 0) ? x : VAL_W'($urandom_range(WIDE_SPAN, 1));
         if (pick < 70)
            send(CMD_SWAP, x, y, any_field());
         else if (pick < 90)
            send(CMD_LOAD, x, any_field(), y);
         else if (pick < 95)
            send(CMD_SWAP, x, '0, any_field());
         else
            send(CMD_UNUSED, x, y, any_field());
      end
   endtask

   initial begin
      int unsigned i, pos4, pos5;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // zero in the register acts as a single value
      write_count_in_use('0);
      send(CMD_LOAD, 1, FIELD_MAX, 1);
      loaded_upto = 1;
      send(CMD_COUNT, '0, '0, '0);
      send(CMD_SWAP, 1, 1, '0);          // equal positions: unchanged total
      send(CMD_SWAP, 1, 2, FIELD_MAX);   // second position out of range: no beat
      drain();

      // directed corner cases on eight values
      write_count_in_use(8);
      load_permutation(8);
      send(CMD_SWAP, 1, 8, '0);          // swap before any count at this size: total may wrap
      send(CMD_COUNT, FIELD_MAX, FIELD_MAX, FIELD_MAX);
      send(CMD_LOAD, 0, FIELD_MAX, 3);   // position below range
      send(CMD_LOAD, 9, '0, 3);          // position above range
      send(CMD_LOAD, 2, '0, '0);         // value below range
      send(CMD_LOAD, FIELD_MAX, FIELD_MAX, FIELD_MAX);
      send(CMD_UNUSED, FIELD_MAX, FIELD_MAX, FIELD_MAX);
      send(CMD_SWAP, 8, 1, FIELD_MAX);   // undoes the first swap
      send(CMD_SWAP, 4, 4, '0);
      send(CMD_SWAP, 0, 3, '0);
      send(CMD_SWAP, 3, 9, '0);
      send(CMD_SWAP, FIELD_MAX, FIELD_MAX, '0);
      // neighbouring values: their contributions overlap
      pos4 = 1;
      pos5 = 1;
      for (i = 0; i < 8; i++) begin
         if (order[i] == 4) pos4 = i + 1;
         if (order[i] == 5) pos5 = i + 1;
      end
      send(CMD_SWAP, pos4, pos5, '0);
      send(CMD_LOAD, 1, '0, 8);          // duplicate value 8: no longer a permutation
      send(CMD_SWAP, 1, 2, '0);
      send(CMD_COUNT, '0, '0, '0);

      // random phases over several sizes
      run_phase(2, 1'b1, 60);
      run_phase(3, 1'b1, 60);
      quiet <= 1'b1;                     // one stretch with no idling at all
      run_phase(5, 1'b1, 100);
      quiet <= 1'b0;
      run_phase(16, 1'b0, 100);          // swaps start from a stale total
      run_phase(100, 1'b1, 100);
      wide_phase(VAL_W'(MAX_VALUES), 20);
      wide_phase(FIELD_MAX, 60);         // saturates to the table size
      run_phase(7, 1'b0, 100);           // shrink: stored values beyond n remain
      run_phase(1, 1'b1, 20);

      drain();
      if (mismatches == 0 && awaited == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

// ----- permutation_swap_round_counter.f -----
design/psrc_pkg.sv
design/psrc_ram.sv
design/psrc_csr.sv
design/psrc_delta.sv
design/psrc_ctrl.sv
design/permutation_swap_round_counter.sv
bench/psrc_round_checker.sv
bench/tb_permutation_swap_round_counter.sv
